FILE: rtl/assert_macros.svh
// assertion macros shared by the matrix multiply rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define MM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/mm_pkg.sv
// shared types, constants and helpers for the matrix multiply block
package mm_pkg;

  localparam int ELEM_W    = 32;
  localparam int DIM_REG_W = 4;
  localparam int TAG_IDX_W = 3;
  localparam int REG_IDX_W = 2;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd4;

  // register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  // saturation limits of the q16.16 result
  localparam logic [ELEM_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WAIT_OUT,
    ST_ISSUE,
    ST_DRAIN
  } ctrl_state_t;

  // per-beat tag that travels down the mac pipeline
  typedef struct packed {
    logic                 first;
    logic                 last;
    logic                 last_run;
    logic [TAG_IDX_W-1:0] row;
    logic [TAG_IDX_W-1:0] col;
  } mm_tag_t;

  typedef struct packed {
    logic    wr_a;
    logic    wr_b;
    logic    rd_en;
    mm_tag_t tag;
  } mm_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic res_done;
  } mm_stat_t;

  // zero counts as one, anything above the maximum is clamped
  function automatic logic [4:0] eff_dim(input logic [DIM_REG_W-1:0] v,
                                         input logic [4:0] max_dim);
    logic [4:0] v_ext;
    v_ext = {1'b0, v};
    if (v == '0) begin
      return 5'd1;
    end else if (v_ext > max_dim) begin
      return max_dim;
    end
    return v_ext;
  endfunction

endpackage

FILE: rtl/mm_ctrl.sv
// controller: load sequencing and dot product issue for the matrix multiply
`include "assert_macros.svh"

module mm_ctrl #(
  parameter int MAX_DIM = 8,
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM),
  localparam int DIM_W  = $clog2(MAX_DIM),
  localparam int DV_W   = DIM_W + 1,
  localparam int LEN_W  = 2 * DV_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [mm_pkg::DIM_REG_W-1:0]     rows_a,
  input  logic [mm_pkg::DIM_REG_W-1:0]     inner_dim,
  input  logic [mm_pkg::DIM_REG_W-1:0]     cols_b,
  input  logic                             cfg_wr,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mm_pkg::mm_stat_t                 stat,
  output mm_pkg::mm_cmd_t                  cmd,
  output logic [ADDR_W-1:0]                wr_addr,
  output logic [ADDR_W-1:0]                rd_a_addr,
  output logic [ADDR_W-1:0]                rd_b_addr
);

  mm_pkg::ctrl_state_t state_r, state_nxt;
  logic              in_b_r, in_b_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [DIM_W-1:0]  i_r, i_nxt;
  logic [DIM_W-1:0]  j_r, j_nxt;
  logic [DIM_W-1:0]  k_r, k_nxt;
  logic [ADDR_W-1:0] a_addr_r, a_addr_nxt;
  logic [ADDR_W-1:0] b_addr_r, b_addr_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;

  logic [DV_W-1:0]  m, n, p;
  logic [LEN_W-1:0] a_len, b_len;
  logic             a_last, b_last, i_last, j_last, k_last;

  // effective dimensions and matrix sizes
  always_comb begin
    m      = DV_W'(mm_pkg::eff_dim(rows_a, 5'(MAX_DIM)));
    n      = DV_W'(mm_pkg::eff_dim(inner_dim, 5'(MAX_DIM)));
    p      = DV_W'(mm_pkg::eff_dim(cols_b, 5'(MAX_DIM)));
    a_len  = LEN_W'(m) * LEN_W'(n);
    b_len  = LEN_W'(n) * LEN_W'(p);
    a_last = (LEN_W'(idx_r) == a_len - LEN_W'(1));
    b_last = (LEN_W'(idx_r) == b_len - LEN_W'(1));
    i_last = (DV_W'(i_r) == m - DV_W'(1));
    j_last = (DV_W'(j_r) == p - DV_W'(1));
    k_last = (DV_W'(k_r) == n - DV_W'(1));
  end

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mm_pkg::ST_LOAD;
      in_b_r     <= 1'b0;
      idx_r      <= '0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      a_addr_r   <= '0;
      b_addr_r   <= '0;
      row_base_r <= '0;
    end else begin
      state_r    <= state_nxt;
      in_b_r     <= in_b_nxt;
      idx_r      <= idx_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      k_r        <= k_nxt;
      a_addr_r   <= a_addr_nxt;
      b_addr_r   <= b_addr_nxt;
      row_base_r <= row_base_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_b_nxt     = in_b_r;
    idx_nxt      = idx_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    a_addr_nxt   = a_addr_r;
    b_addr_nxt   = b_addr_r;
    row_base_nxt = row_base_r;
    in_ready     = 1'b0;
    cmd          = '0;
    wr_addr      = idx_r;
    rd_a_addr    = a_addr_r;
    rd_b_addr    = b_addr_r;

    case (state_r)
      mm_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_a = !in_b_r;
          cmd.wr_b = in_b_r;
          if (!in_b_r) begin
            if (a_last) begin
              in_b_nxt = 1'b1;
              idx_nxt  = '0;
            end else begin
              idx_nxt = idx_r + ADDR_W'(1);
            end
          end else if (b_last) begin
            // last b word starts the product
            in_b_nxt     = 1'b0;
            idx_nxt      = '0;
            i_nxt        = '0;
            j_nxt        = '0;
            k_nxt        = '0;
            a_addr_nxt   = '0;
            b_addr_nxt   = '0;
            row_base_nxt = '0;
            state_nxt    = mm_pkg::ST_WAIT_OUT;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
      end

      mm_pkg::ST_WAIT_OUT: begin
        if (!stat.out_busy) begin
          state_nxt = mm_pkg::ST_ISSUE;
        end
      end

      // one multiply-accumulate beat per cycle along a row and a column
      mm_pkg::ST_ISSUE: begin
        cmd.rd_en        = 1'b1;
        cmd.tag.first    = (k_r == '0);
        cmd.tag.last     = k_last;
        cmd.tag.last_run = i_last && j_last;
        cmd.tag.row      = mm_pkg::TAG_IDX_W'(i_r);
        cmd.tag.col      = mm_pkg::TAG_IDX_W'(j_r);
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = mm_pkg::ST_DRAIN;
        end else begin
          k_nxt      = k_r + DIM_W'(1);
          a_addr_nxt = a_addr_r + ADDR_W'(1);
          b_addr_nxt = b_addr_r + ADDR_W'(p);
        end
      end

      // wait for the sum to land in the output register
      mm_pkg::ST_DRAIN: begin
        if (stat.res_done) begin
          if (i_last && j_last) begin
            state_nxt = mm_pkg::ST_LOAD;
          end else begin
            state_nxt = mm_pkg::ST_WAIT_OUT;
            if (j_last) begin
              j_nxt        = '0;
              i_nxt        = i_r + DIM_W'(1);
              row_base_nxt = row_base_r + ADDR_W'(n);
              a_addr_nxt   = row_base_r + ADDR_W'(n);
              b_addr_nxt   = '0;
            end else begin
              j_nxt      = j_r + DIM_W'(1);
              a_addr_nxt = row_base_r;
              b_addr_nxt = ADDR_W'(j_r) + ADDR_W'(1);
            end
          end
        end
      end

      default: begin
        state_nxt = mm_pkg::ST_LOAD;
      end
    endcase

    // a register write restarts loading with the first a word
    if (cfg_wr) begin
      in_b_nxt = 1'b0;
      idx_nxt  = '0;
    end
  end

  `MM_ASSERT(a_k_in_range, (state_r == mm_pkg::ST_ISSUE) |-> (DV_W'(k_r) < n), "k beyond inner dim")
  `MM_ASSERT(a_done_in_drain, stat.res_done |-> (state_r == mm_pkg::ST_DRAIN), "result outside drain")

endmodule

FILE: rtl/mm_dp.sv
// datapath: operand stores, multiply-accumulate pipeline and result register
`include "assert_macros.svh"

module mm_dp #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16,
  localparam int DEPTH    = MAX_DIM * MAX_DIM,
  localparam int ADDR_W   = $clog2(DEPTH),
  localparam int ACC_W    = 64 + $clog2(MAX_DIM) + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mm_pkg::mm_cmd_t                   cmd,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  logic [ADDR_W-1:0]                 rd_a_addr,
  input  logic [ADDR_W-1:0]                 rd_b_addr,
  input  logic signed [mm_pkg::ELEM_W-1:0]  in_element,
  output mm_pkg::mm_stat_t                  stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mm_pkg::ELEM_W-1:0]  out_product_element,
  output logic [mm_pkg::TAG_IDX_W-1:0]      out_row,
  output logic [mm_pkg::TAG_IDX_W-1:0]      out_col,
  output logic                              out_saturated,
  output logic                              out_last_of_run
);

  logic [mm_pkg::ELEM_W-1:0] a_mem [DEPTH];
  logic [mm_pkg::ELEM_W-1:0] b_mem [DEPTH];

  logic                      s1_v_r, s2_v_r, done_r;
  mm_pkg::mm_tag_t           s1_tag_r, s2_tag_r, s3_tag_r;
  logic [mm_pkg::ELEM_W-1:0] a_q_r, b_q_r;
  logic signed [63:0]        prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_sh;
  logic [ACC_W-32:0]         acc_hi;
  logic                      fits;
  logic [mm_pkg::ELEM_W-1:0] res_val;

  logic                      out_valid_r;
  logic [mm_pkg::ELEM_W-1:0] out_elem_r;
  mm_pkg::mm_tag_t           out_tag_r;
  logic                      out_sat_r;

  // operand stores, written while loading
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      a_mem[wr_addr] <= in_element;
    end
    if (cmd.wr_b) begin
      b_mem[wr_addr] <= in_element;
    end
  end

  // registered operand reads
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      a_q_r <= a_mem[rd_a_addr];
      b_q_r <= b_mem[rd_b_addr];
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.rd_en;
      s2_v_r <= s1_v_r;
      done_r <= s2_v_r && s2_tag_r.last;
    end
  end

  // multiply and accumulate stages
  always_ff @(posedge clk) begin
    s1_tag_r <= cmd.tag;
    if (s1_v_r) begin
      prod_r   <= $signed(a_q_r) * $signed(b_q_r);
      s2_tag_r <= s1_tag_r;
    end
    if (s2_v_r) begin
      s3_tag_r <= s2_tag_r;
      if (s2_tag_r.first) begin
        acc_r <= {{(ACC_W-64){prod_r[63]}}, prod_r};
      end else begin
        acc_r <= acc_r + {{(ACC_W-64){prod_r[63]}}, prod_r};
      end
    end
  end

  // drop the fraction bits and clamp to 32 bits
  always_comb begin
    acc_sh  = acc_r >>> FRAC_BITS;
    acc_hi  = acc_sh[ACC_W-1:31];
    fits    = (&acc_hi) || !(|acc_hi);
    if (fits) begin
      res_val = acc_sh[31:0];
    end else if (acc_sh[ACC_W-1]) begin
      res_val = mm_pkg::Q_MIN;
    end else begin
      res_val = mm_pkg::Q_MAX;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_r) begin
      out_elem_r <= res_val;
      out_tag_r  <= s3_tag_r;
      out_sat_r  <= !fits;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_product_element = out_elem_r;
  assign out_row             = out_tag_r.row;
  assign out_col             = out_tag_r.col;
  assign out_saturated       = out_sat_r;
  assign out_last_of_run     = out_tag_r.last_run;

  assign stat.out_busy = out_valid_r && !out_ready;
  assign stat.res_done = done_r;

  `MM_NEVER(a_no_overwrite, done_r && out_valid_r && !out_ready, "result overwrites waiting word")

endmodule

FILE: rtl/matrix_multiply_core.sv
// Sequence: after the last B word the controller waits while an output word is still waiting,
// then issues one mac beat per inner step; the sum passes the read, multiply, accumulate and
// output stages before the product word is valid. Loading takes one word per cycle; no words
// are taken while products are computed, and rows_a * cols_b product words are made per matrix.
// Reset (synchronous, active low): dimensions return to 4, loading restarts with
// the first A word; the operand stores are not cleared.
module matrix_multiply_core #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // element input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [mm_pkg::ELEM_W-1:0]  in_element,
  // product output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mm_pkg::ELEM_W-1:0]  out_product_element,
  output logic [mm_pkg::TAG_IDX_W-1:0]      out_row,
  output logic [mm_pkg::TAG_IDX_W-1:0]      out_col,
  output logic                              out_saturated,
  output logic                              out_last_of_run,
  // apb configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  logic [mm_pkg::DIM_REG_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic                         cfg_wr;
  logic                         cfg_restart;
  logic [mm_pkg::REG_IDX_W-1:0] reg_idx;
  mm_pkg::mm_cmd_t              cmd;
  mm_pkg::mm_stat_t             stat;
  logic [ADDR_W-1:0]            wr_addr, rd_a_addr, rd_b_addr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // only writes that land on a dimension register restart loading
  assign cfg_restart = cfg_wr &&
    (reg_idx inside {mm_pkg::REG_ROWS_A, mm_pkg::REG_INNER_DIM, mm_pkg::REG_COLS_B});

  // dimension registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= mm_pkg::DIM_RESET;
      inner_dim_r <= mm_pkg::DIM_RESET;
      cols_b_r    <= mm_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        mm_pkg::REG_ROWS_A:    rows_a_r    <= pwdata[mm_pkg::DIM_REG_W-1:0];
        mm_pkg::REG_INNER_DIM: inner_dim_r <= pwdata[mm_pkg::DIM_REG_W-1:0];
        mm_pkg::REG_COLS_B:    cols_b_r    <= pwdata[mm_pkg::DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      mm_pkg::REG_ROWS_A:    prdata = 32'(rows_a_r);
      mm_pkg::REG_INNER_DIM: prdata = 32'(inner_dim_r);
      mm_pkg::REG_COLS_B:    prdata = 32'(cols_b_r);
      default:               prdata = '0;
    endcase
  end

  mm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .rows_a    (rows_a_r),
    .inner_dim (inner_dim_r),
    .cols_b    (cols_b_r),
    .cfg_wr    (cfg_restart),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr)
  );

  mm_dp #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .wr_addr             (wr_addr),
    .rd_a_addr           (rd_a_addr),
    .rd_b_addr           (rd_b_addr),
    .in_element          (in_element),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_product_element (out_product_element),
    .out_row             (out_row),
    .out_col             (out_col),
    .out_saturated       (out_saturated),
    .out_last_of_run     (out_last_of_run)
  );

endmodule
